// ----- hdl/slkc_pkg.sv -----
// ----------------------------------------------------------------------------
// slkc_pkg: shared types and constants of the source lexer
// Request payloads, result grouping, token kind codes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package slkc_pkg;

  // input request: one source byte
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_source;
  } in_t;

  // result request: one token
  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  bad_char;
    logic        last_of_run;
  } out_t;

  // most results that one byte can cause
  localparam int MAX_RES = 3;

  // results of one byte, in order, handed from the lexer to the result queue
  typedef struct packed {
    logic [1:0]              count;
    out_t [MAX_RES-1:0]      item;
  } res_grp_t;

  // result queue geometry
  localparam int QDEPTH    = 8;
  localparam int QPTR_BITS = 3;
  localparam int QCNT_BITS = 4;

  // token kinds
  localparam logic [4:0] KIND_EXIT   = 5'd0;
  localparam logic [4:0] KIND_LET    = 5'd1;
  localparam logic [4:0] KIND_IF     = 5'd2;
  localparam logic [4:0] KIND_IDENT  = 5'd3;
  localparam logic [4:0] KIND_INT    = 5'd4;
  localparam logic [4:0] KIND_SEMI   = 5'd5;
  localparam logic [4:0] KIND_LPAREN = 5'd6;
  localparam logic [4:0] KIND_RPAREN = 5'd7;
  localparam logic [4:0] KIND_ASSIGN = 5'd8;
  localparam logic [4:0] KIND_PLUS   = 5'd9;
  localparam logic [4:0] KIND_MINUS  = 5'd10;
  localparam logic [4:0] KIND_STAR   = 5'd11;
  localparam logic [4:0] KIND_SLASH  = 5'd12;
  localparam logic [4:0] KIND_LBRACE = 5'd13;
  localparam logic [4:0] KIND_RBRACE = 5'd14;
  localparam logic [4:0] KIND_END    = 5'd15;
  localparam logic [4:0] KIND_ERROR  = 5'd16;
  localparam logic [4:0] KIND_NONE   = 5'd31;

  // character codes
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // single-byte punctuator kind, KIND_NONE if the byte is not one
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h3B:   k = KIND_SEMI;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3D:   k = KIND_ASSIGN;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/slkc_core.sv -----
// ----------------------------------------------------------------------------
// slkc_core: lexer state and per-byte token generation
// Holds mode, position and current token; produces up to three results per
// accepted byte in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slkc_core import slkc_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire in_t      in_data,
  output res_grp_t      res
);

  typedef enum logic [7:0] {
    M_IDLE  = 8'b0000_0001,
    M_WORD  = 8'b0000_0010,
    M_NUM   = 8'b0000_0100,
    M_SLASH = 8'b0000_1000,
    M_LINE  = 8'b0001_0000,
    M_BLOCK = 8'b0010_0000,
    M_BSTAR = 8'b0100_0000,
    M_HALT  = 8'b1000_0000
  } mode_t;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [POS_BITS-1:0] len_r, len_nxt;
  logic [3:0][7:0]     pref_r, pref_nxt;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [15:0] clip16(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [4:0] word_kind(input logic [3:0][7:0] p,
                                           input logic [POS_BITS-1:0] n);
    logic [4:0] k;
    k = KIND_IDENT;
    if (n == POS_BITS'(4) && p[0] == "e" && p[1] == "x" && p[2] == "i" &&
        p[3] == "t")
      k = KIND_EXIT;
    else if (n == POS_BITS'(3) && p[0] == "l" && p[1] == "e" && p[2] == "t")
      k = KIND_LET;
    else if (n == POS_BITS'(2) && p[0] == "i" && p[1] == "f")
      k = KIND_IF;
    return k;
  endfunction

  function automatic out_t mk(input logic [4:0] kind, input logic [POS_BITS-1:0] s,
                              input logic [POS_BITS-1:0] n, input logic [7:0] bad);
    out_t r;
    r.token_kind   = kind;
    r.token_start  = clip16(s);
    r.token_length = clip16(n);
    r.bad_char     = bad;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // byte classes
  logic [7:0] c;
  logic       is_alpha, is_digit, is_space, last;
  logic [4:0] pk;

  assign c        = in_data.ch;
  assign last     = in_data.end_of_source;
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign pk       = punct_kind(c);

  // candidates: flushed token, new single token, pending token at end, end
  logic [3:0] cv;
  out_t [3:0] ca;
  logic       done;
  logic [1:0] n;

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pref_nxt  = pref_r;
    done      = 1'b0;
    cv        = '0;
    ca        = '0;
    res       = '0;
    n         = 2'd0;

    // continue or close the current mode
    unique case (mode_r)
      M_WORD: begin
        if (is_alpha || is_digit) begin
          if (len_r < POS_BITS'(4))
            pref_nxt[len_r[1:0]] = c;
          len_nxt = sat_inc(len_r);
          done    = 1'b1;
        end else begin
          cv[0]    = 1'b1;
          ca[0]    = mk(word_kind(pref_r, len_r), start_r, len_r, 8'd0);
          mode_nxt = M_IDLE;
        end
      end
      M_NUM: begin
        if (is_digit) begin
          len_nxt = sat_inc(len_r);
          done    = 1'b1;
        end else begin
          cv[0]    = 1'b1;
          ca[0]    = mk(KIND_INT, start_r, len_r, 8'd0);
          mode_nxt = M_IDLE;
        end
      end
      M_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = M_LINE;
          done     = 1'b1;
        end else if (c == CH_STAR) begin
          mode_nxt = M_BLOCK;
          done     = 1'b1;
        end else begin
          cv[0]    = 1'b1;
          ca[0]    = mk(KIND_SLASH, start_r, POS_ONE, 8'd0);
          mode_nxt = M_IDLE;
        end
      end
      M_LINE: begin
        if (c == CH_NL)
          mode_nxt = M_IDLE;
        done = 1'b1;
      end
      M_BLOCK: begin
        if (c == CH_STAR)
          mode_nxt = M_BSTAR;
        done = 1'b1;
      end
      M_BSTAR: begin
        if (c == CH_SLASH)
          mode_nxt = M_IDLE;
        else if (c != CH_STAR)
          mode_nxt = M_BLOCK;
        done = 1'b1;
      end
      M_HALT: begin
        done = 1'b1;
      end
      M_IDLE: begin
        mode_nxt = M_IDLE;
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    // start a new token from this byte
    if (!done) begin
      priority if (is_alpha) begin
        mode_nxt  = M_WORD;
        start_nxt = pos_r;
        len_nxt   = POS_ONE;
        pref_nxt  = '0;
        pref_nxt[0] = c;
      end else if (is_digit) begin
        mode_nxt  = M_NUM;
        start_nxt = pos_r;
        len_nxt   = POS_ONE;
      end else if (c == CH_SLASH) begin
        mode_nxt  = M_SLASH;
        start_nxt = pos_r;
        len_nxt   = POS_ONE;
      end else if (pk != KIND_NONE) begin
        cv[1] = 1'b1;
        ca[1] = mk(pk, pos_r, POS_ONE, 8'd0);
      end else if (!is_space) begin
        cv[1]    = 1'b1;
        ca[1]    = mk(KIND_ERROR, pos_r, POS_ONE, c);
        mode_nxt = M_HALT;
      end
    end

    pos_nxt = sat_inc(pos_r);

    // end of source: flush, report end unless halted, return to reset values
    if (last) begin
      if (mode_nxt == M_WORD) begin
        cv[2] = 1'b1;
        ca[2] = mk(word_kind(pref_nxt, len_nxt), start_nxt, len_nxt, 8'd0);
      end else if (mode_nxt == M_NUM) begin
        cv[2] = 1'b1;
        ca[2] = mk(KIND_INT, start_nxt, len_nxt, 8'd0);
      end else if (mode_nxt == M_SLASH) begin
        cv[2] = 1'b1;
        ca[2] = mk(KIND_SLASH, start_nxt, POS_ONE, 8'd0);
      end
      if (mode_nxt != M_HALT) begin
        cv[3] = 1'b1;
        ca[3] = mk(KIND_END, pos_nxt, '0, 8'd0);
      end
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      pref_nxt  = '0;
    end

    // pack the valid candidates in order
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && n != 2'd3) begin
        res.item[n] = ca[i];
        n = n + 2'd1;
      end
    end
    for (int i = 0; i < MAX_RES; i++)
      res.item[i].last_of_run = (n == 2'(i + 1));
    res.count = n;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      pref_r  <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pref_r  <= pref_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/slkc_fifo.sv -----
// ----------------------------------------------------------------------------
// slkc_fifo: result queue
// Takes up to three results at once; hands out one per cycle while out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module slkc_fifo import slkc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_en,
  input  wire res_grp_t push,
  output logic          room,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_t          out_data
);

  out_t [QDEPTH-1:0]    q_r;
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]           push_n;
  logic                 pop;

  // room for a full group of results
  assign room      = (cnt_r <= QCNT_BITS'(QDEPTH - MAX_RES));
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign push_n    = push_en ? push.count : 2'd0;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(push_n);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(pop);
    cnt_nxt    = cnt_r + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_n)
        q_r[QPTR_BITS'(wr_ptr_r + QPTR_BITS'(i))] <= push.item[i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/source_lexer_keywords_comments.sv -----
// A byte's results are written into the queue as the byte is accepted, in order.
// Throughput: one byte per cycle; results leave one per cycle through an
// eight-entry queue, so bytes causing several results are paced by the output.
// in_ready drops while fewer than three queue entries are free.
// Reset (synchronous, rst_n low) empties the queue and returns the lexer to idle
// at position zero.
// ----------------------------------------------------------------------------
// source_lexer_keywords_comments: streaming lexer top level
// Lexer state machine followed by a result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module source_lexer_keywords_comments import slkc_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic     in_fire;
  res_grp_t res;

  // byte request accepted
  assign in_fire = in_valid && in_ready;

  slkc_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .res     (res)
  );

  slkc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_fire),
    .push      (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
